FILE: rtl/stt_pkg.sv
// ----------------------------------------------------------------------------
// stt_pkg
// Shared commands, states and constants of the scrolling text ticker.
// ----------------------------------------------------------------------------
package stt_pkg;

  localparam int unsigned GlyphCount = 95;
  localparam int unsigned FirstCode  = 32;
  localparam int unsigned EndCode    = 127;

  typedef enum logic [2:0] {
    CMD_LOAD_WIDTH = 3'd0,
    CMD_LOAD_START = 3'd1,
    CMD_LOAD_FONT  = 3'd2,
    CMD_START      = 3'd3,
    CMD_APPEND     = 3'd4,
    CMD_FINISH     = 3'd5,
    CMD_TICK       = 3'd6,
    CMD_NONE       = 3'd7
  } cmd_e;

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_CLEAR  = 7'b0000010,
    ST_GLYPH  = 7'b0000100,
    ST_COPY   = 7'b0001000,
    ST_TICK   = 7'b0010000,
    ST_FLUSH  = 7'b0100000,
    ST_GLYPH2 = 7'b1000000
  } state_e;

endpackage

FILE: rtl/scrolling_text_ticker.sv
// ----------------------------------------------------------------------------
// scrolling_text_ticker
// Proportional font ticker with a paged column buffer and framed output.
// ----------------------------------------------------------------------------
// channel   direction  handshake
// command   in         start while busy low
// result    out        strobe_o, one cycle, no stall
//
// loads, finish, an ignored command and a tick while off: busy stays low
// start message: busy while the buffer is cleared
// append: busy while the glyph is looked up and, when a glyph is drawn, while it is copied
// tick: busy while the visible window is read, one buffer byte per cycle
// after reset the buffer is cleared by a pass over all of it, busy high
// the receiver cannot stall; a tick sends its bytes packed eight to a word
module scrolling_text_ticker #(
  parameter int unsigned BUFFER_COLUMNS  = 320,
  parameter int unsigned ROW_PAGES       = 3,
  parameter int unsigned FONT_BYTES      = 4096,
  parameter int unsigned VISIBLE_COLUMNS = 128,
  parameter int unsigned RESTART_GAP     = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  command_i,
  input  logic [11:0] table_index_i,
  input  logic [11:0] table_value_i,
  input  logic [7:0]  char_code_i,
  output logic        strobe_o,
  output logic [63:0] frame_bytes_o,
  output logic        last_word_o
);

  localparam int unsigned Depth = ROW_PAGES * BUFFER_COLUMNS;
  localparam int unsigned AW    = $clog2(Depth);
  localparam int unsigned Frame = ROW_PAGES * VISIBLE_COLUMNS;
  localparam int unsigned FW    = $clog2(Frame + 1);
  localparam int unsigned PW    = $clog2(ROW_PAGES + 1);
  localparam int unsigned VW    = $clog2(VISIBLE_COLUMNS + 1);

  stt_pkg::state_e state_q, state_d;
  logic          accept;
  stt_pkg::cmd_e cmd;
  logic          slot_ok;

  logic [8:0]  text_end_q, scroll_q, wrap_q;
  logic        stopped_q, seen_q;
  logic [6:0]  slot_q;
  logic [AW-1:0] clr_q;
  logic [PW-1:0] page_q;
  logic [5:0]  x_q, w_q;
  logic [11:0] faddr_q;
  logic [AW-1:0] wbase_q;
  logic        wv_q;
  logic [AW-1:0] wa_q;
  logic [VW-1:0] vx_q;
  logic [8:0]  col_q;
  logic [FW-1:0] n_q;
  logic        rv_q;
  logic        rlast_q;
  logic [63:0] word_q;

  logic [5:0]  g_width;
  logic [11:0] g_start, font_rd;
  logic [7:0]  font_byte, col_byte;
  logic        col_we;
  logic [AW-1:0] col_wa, col_ra;
  logic [7:0]  col_wd;

  assign accept  = start && !busy;
  assign busy    = state_q != stt_pkg::ST_IDLE;
  assign cmd     = stt_pkg::cmd_e'(command_i);
  assign slot_ok = 32'(table_index_i) < stt_pkg::GlyphCount;

  stt_font #(.FONT_BYTES(FONT_BYTES)) u_font (
    .clk_i     (clk_i),
    .wr_width_i(accept && cmd == stt_pkg::CMD_LOAD_WIDTH && slot_ok),
    .wr_start_i(accept && cmd == stt_pkg::CMD_LOAD_START && slot_ok),
    .wr_font_i (accept && cmd == stt_pkg::CMD_LOAD_FONT && 32'(table_index_i) < FONT_BYTES),
    .slot_wr_i (table_index_i[6:0]),
    .addr_wr_i (table_index_i),
    .value_i   (table_value_i),
    .slot_rd_i (slot_q),
    .font_rd_i (font_rd),
    .width_o   (g_width),
    .start_o   (g_start),
    .font_o    (font_byte)
  );

  assign font_rd = faddr_q + 12'(x_q);

  stt_columns #(.DEPTH(Depth), .AW(AW)) u_cols (
    .clk_i  (clk_i),
    .we_i   (col_we),
    .waddr_i(col_wa),
    .wdata_i(col_wd),
    .raddr_i(col_ra),
    .rdata_o(col_byte)
  );

  // buffer write mux: clearing pass or delayed glyph copy
  always_comb begin
    col_we = 1'b0;
    col_wa = clr_q;
    col_wd = 8'd0;
    if (state_q == stt_pkg::ST_CLEAR) begin
      col_we = 1'b1;
    end else if (wv_q) begin
      col_we = 1'b1;
      col_wa = wa_q;
      col_wd = font_byte;
    end
  end

  assign col_ra = AW'(32'(page_q) * BUFFER_COLUMNS + 32'(col_q));

  // control sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      stt_pkg::ST_IDLE: begin
        if (accept && cmd == stt_pkg::CMD_START) state_d = stt_pkg::ST_CLEAR;
        else if (accept && cmd == stt_pkg::CMD_APPEND && !stopped_q && char_code_i != 8'd0)
          state_d = stt_pkg::ST_GLYPH;
        else if (accept && cmd == stt_pkg::CMD_TICK && wrap_q != 9'd0)
          state_d = stt_pkg::ST_TICK;
      end
      stt_pkg::ST_CLEAR:  if (32'(clr_q) == Depth - 1) state_d = stt_pkg::ST_IDLE;
      stt_pkg::ST_GLYPH:  state_d = stt_pkg::ST_GLYPH2;
      stt_pkg::ST_GLYPH2: begin
        if (32'(text_end_q) + 32'(g_width) > BUFFER_COLUMNS || g_width == 6'd0)
          state_d = stt_pkg::ST_FLUSH;
        else state_d = stt_pkg::ST_COPY;
      end
      stt_pkg::ST_COPY: begin
        if (x_q == w_q - 6'd1 && 32'(page_q) == ROW_PAGES - 1) state_d = stt_pkg::ST_FLUSH;
      end
      stt_pkg::ST_TICK: begin
        if (32'(page_q) == ROW_PAGES - 1 && 32'(vx_q) == VISIBLE_COLUMNS - 1)
          state_d = stt_pkg::ST_FLUSH;
      end
      stt_pkg::ST_FLUSH:  if (!wv_q && !rv_q) state_d = stt_pkg::ST_IDLE;
      default:            state_d = stt_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= stt_pkg::ST_CLEAR;
      clr_q      <= '0;
      text_end_q <= '0;
      scroll_q   <= '0;
      wrap_q     <= '0;
      stopped_q  <= 1'b0;
      seen_q     <= 1'b0;
      wv_q       <= 1'b0;
      wa_q       <= '0;
      rv_q       <= 1'b0;
      rlast_q    <= 1'b0;
      n_q        <= '0;
      strobe_o   <= 1'b0;
    end else begin
      state_q  <= state_d;
      wv_q     <= 1'b0;
      rv_q     <= 1'b0;
      strobe_o <= 1'b0;
      unique case (state_q)
        stt_pkg::ST_IDLE: begin
          clr_q <= '0;
          if (accept) begin
            unique case (cmd)
              stt_pkg::CMD_START: begin
                text_end_q <= '0;
                stopped_q  <= 1'b0;
                seen_q     <= 1'b0;
                wrap_q     <= '0;
                scroll_q   <= '0;
              end
              stt_pkg::CMD_APPEND: begin
                seen_q <= 1'b1;
                if (!stopped_q && char_code_i == 8'd0) stopped_q <= 1'b1;
              end
              stt_pkg::CMD_FINISH: begin
                stopped_q <= 1'b1;
                scroll_q  <= '0;
                if (!seen_q) wrap_q <= '0;
                else if (32'(text_end_q) + RESTART_GAP < VISIBLE_COLUMNS)
                  wrap_q <= 9'(VISIBLE_COLUMNS);
                else if (32'(text_end_q) + RESTART_GAP > BUFFER_COLUMNS)
                  wrap_q <= 9'(BUFFER_COLUMNS);
                else wrap_q <= 9'(32'(text_end_q) + RESTART_GAP);
              end
              default: ;
            endcase
          end
        end
        stt_pkg::ST_CLEAR: clr_q <= clr_q + AW'(1);
        stt_pkg::ST_GLYPH2: begin
          if (32'(text_end_q) + 32'(g_width) > BUFFER_COLUMNS) stopped_q <= 1'b1;
          else text_end_q <= text_end_q + 9'(g_width);
        end
        stt_pkg::ST_COPY: begin
          wv_q <= 1'b1;
          wa_q <= wbase_q + AW'(x_q);
        end
        stt_pkg::ST_TICK: begin
          rv_q    <= 1'b1;
          rlast_q <= 32'(page_q) == ROW_PAGES - 1 && 32'(vx_q) == VISIBLE_COLUMNS - 1;
        end
        stt_pkg::ST_FLUSH: begin
          if (!wv_q && !rv_q && n_q != '0) begin
            scroll_q <= (scroll_q + 9'd1 >= wrap_q) ? 9'd0 : scroll_q + 9'd1;
            n_q      <= '0;
          end
        end
        default: ;
      endcase
      // pack read bytes into words
      if (rv_q) begin
        n_q <= n_q + FW'(1);
        if (n_q[2:0] == 3'd7 || rlast_q) strobe_o <= 1'b1;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      stt_pkg::ST_IDLE: begin
        slot_q <= (char_code_i < 8'(stt_pkg::FirstCode) ||
                   char_code_i >= 8'(stt_pkg::EndCode)) ? 7'd0 :
                  7'(char_code_i - 8'(stt_pkg::FirstCode));
        page_q <= '0;
        x_q    <= '0;
        vx_q   <= '0;
        col_q  <= scroll_q;
        wbase_q <= AW'(text_end_q);
      end
      stt_pkg::ST_GLYPH2: begin
        faddr_q <= g_start;
        w_q     <= g_width;
      end
      stt_pkg::ST_COPY: begin
        if (x_q == w_q - 6'd1) begin
          x_q     <= '0;
          page_q  <= page_q + PW'(1);
          faddr_q <= faddr_q + 12'(w_q);
          wbase_q <= wbase_q + AW'(BUFFER_COLUMNS);
        end else x_q <= x_q + 6'd1;
      end
      stt_pkg::ST_TICK: begin
        if (32'(vx_q) == VISIBLE_COLUMNS - 1) begin
          vx_q   <= '0;
          page_q <= page_q + PW'(1);
          col_q  <= scroll_q;
        end else begin
          vx_q  <= vx_q + VW'(1);
          col_q <= (col_q + 9'd1 >= wrap_q) ? 9'd0 : col_q + 9'd1;
        end
      end
      default: ;
    endcase
    if (rv_q) begin
      if (n_q[2:0] == 3'd0) word_q <= {56'd0, col_byte};
      else word_q <= word_q | (64'(col_byte) << {n_q[2:0], 3'b000});
    end
  end

  // result ports
  logic last_q;
  always_ff @(posedge clk_i) begin
    if (rv_q) begin
      last_q <= rlast_q;
      frame_bytes_o <= (n_q[2:0] == 3'd0) ? {56'd0, col_byte} :
                       word_q | (64'(col_byte) << {n_q[2:0], 3'b000});
    end
  end
  assign last_word_o = last_q;

`ifndef NO_ASSERTIONS
  a_no_strobe_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |-> $past(rv_q)) else $error("strobe without read");
  a_busy_after_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && cmd == stt_pkg::CMD_TICK && wrap_q != 9'd0) |=> busy)
    else $error("tick not taken");
  a_onehot_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q)) else $error("state not one-hot");
  a_text_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(text_end_q) <= BUFFER_COLUMNS) else $error("text end beyond buffer");
`endif

endmodule

FILE: rtl/stt_font.sv
// ----------------------------------------------------------------------------
// stt_font
// Font memories: glyph widths, glyph starts and the glyph byte store.
// ----------------------------------------------------------------------------
module stt_font #(
  parameter int unsigned FONT_BYTES = 4096
) (
  input  logic        clk_i,
  input  logic        wr_width_i,
  input  logic        wr_start_i,
  input  logic        wr_font_i,
  input  logic [6:0]  slot_wr_i,
  input  logic [11:0] addr_wr_i,
  input  logic [11:0] value_i,
  input  logic [6:0]  slot_rd_i,
  input  logic [11:0] font_rd_i,
  output logic [5:0]  width_o,
  output logic [11:0] start_o,
  output logic [7:0]  font_o
);

  logic [5:0]  width_mem [stt_pkg::GlyphCount];
  logic [11:0] start_mem [stt_pkg::GlyphCount];
  logic [7:0]  font_mem  [FONT_BYTES];
  logic        font_hit_q;
  logic [7:0]  font_q;

  // glyph tables
  always_ff @(posedge clk_i) begin
    if (wr_width_i) width_mem[slot_wr_i] <= value_i[5:0];
    if (wr_start_i) start_mem[slot_wr_i] <= value_i;
    width_o <= width_mem[slot_rd_i];
    start_o <= start_mem[slot_rd_i];
  end

  // glyph byte store, out of range reads as zero
  always_ff @(posedge clk_i) begin
    if (wr_font_i) font_mem[addr_wr_i[$clog2(FONT_BYTES)-1:0]] <= value_i[7:0];
    font_q     <= font_mem[font_rd_i[$clog2(FONT_BYTES)-1:0]];
    font_hit_q <= 32'(font_rd_i) < FONT_BYTES;
  end

  assign font_o = font_hit_q ? font_q : 8'd0;

endmodule

FILE: rtl/stt_columns.sv
// ----------------------------------------------------------------------------
// stt_columns
// Column buffer memory, one byte per page column.
// ----------------------------------------------------------------------------
module stt_columns #(
  parameter int unsigned DEPTH = 960,
  parameter int unsigned AW    = 10
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [7:0]    wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [7:0]    rdata_o
);

  logic [7:0] mem [DEPTH];

  // one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end

endmodule
